### rtl/cap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cap_pkg
// Shared codes and limits for call argument placement: command codes,
// calling conventions, destination kinds and register file sizes.
// ----------------------------------------------------------------------------
package cap_pkg;

  // Command carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_ARG   = 2'd1,
    FUNC_END   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // Calling conventions
  typedef enum logic [1:0] {
    ABI_SYSV  = 2'd0,
    ABI_WIN   = 2'd1,
    ABI_X86   = 2'd2,
    ABI_AAPCS = 2'd3
  } abi_e;

  // Destination kind carried on the output tuser
  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_INT    = 3'd1,
    KIND_FP     = 3'd2,
    KIND_STACK  = 3'd3,
    KIND_REPORT = 3'd4
  } kind_e;

  localparam logic [3:0] SysvIntRegs  = 4'd6;
  localparam logic [3:0] AapcsIntRegs = 4'd8;
  localparam logic [3:0] FpRegs       = 4'd8;
  localparam logic [2:0] WinSlots     = 3'd4;
  localparam logic [7:0] FpPosLimit   = 8'd8;
  localparam logic [7:0] PosMax       = 8'd255;
  localparam logic [3:0] NarrowBytes  = 4'd4;
  localparam logic [3:0] WideBytes    = 4'd8;

  // Input tdata layout
  localparam int unsigned InDataW = 136;

endpackage

### rtl/call_argument_placement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_argument_placement
// Assigns each call argument to an integer register, an FP register or a
// stack offset under one of four calling conventions, and reports counts.
// ----------------------------------------------------------------------------
// Result: registered, shown on the master side in the cycle after the input transfer.
// Throughput: one item per cycle unless the master side stalls; placement is
// a few counter compares and one increment, resolved as the transfer loads the result register.
// A held result does not stop the next transfer when the master side is taken.
// Reset: asynchronous, clears all counters, selects SysV x64, empties output.
module call_argument_placement #(
  parameter int unsigned STACK_BYTES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // abi[1:0], has_struct_return[2], struct_address[66:3], is_fp[67],
  // value[131:68], zero fill up to 136 bits
  input  logic [cap_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,     // func
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // reg_index, stack_offset, data, byte_width, clear_partner, dropped,
  // int_count, fp_count, stack_bytes, total_args (low to high), zero fill
  output logic [((89 + 2 * $clog2(STACK_BYTES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser,     // dest_kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int unsigned SW    = $clog2(STACK_BYTES + 1);
  localparam int unsigned OutW  = ((89 + 2 * SW + 7) / 8) * 8;
  localparam int unsigned UsedW = 89 + 2 * SW;
  localparam logic [SW:0] StackLimit = (SW + 1)'(STACK_BYTES);

  // Input fields
  logic [1:0]  in_abi;
  logic        in_hsr;
  logic [63:0] in_saddr;
  logic        in_is_fp;
  logic [63:0] in_value;
  cap_pkg::func_e in_func;

  assign in_abi   = s_axis_tdata[1:0];
  assign in_hsr   = s_axis_tdata[2];
  assign in_saddr = s_axis_tdata[66:3];
  assign in_is_fp = s_axis_tdata[67];
  assign in_value = s_axis_tdata[131:68];
  assign in_func  = cap_pkg::func_e'(s_axis_tuser);

  // Call state
  cap_pkg::abi_e abi_q, abi_d;
  logic [3:0]    int_q, int_d;
  logic [3:0]    fp_q, fp_d;
  logic [2:0]    slot_q, slot_d;
  logic [SW-1:0] stk_q, stk_d;
  logic [7:0]    pos_q, pos_d;

  // Result register
  logic          out_valid_q;
  cap_pkg::kind_e kind_q, kind_d;
  logic [2:0]    reg_q, reg_d;
  logic [SW-1:0] off_q, off_d;
  logic [63:0]   data_q, data_d;
  logic [3:0]    bw_q, bw_d;
  logic          clr_q, clr_d;
  logic          drop_q, drop_d;
  logic [3:0]    ic_q, ic_d;
  logic [3:0]    fc_q, fc_d;
  logic [SW-1:0] sb_q, sb_d;
  logic [7:0]    ta_q, ta_d;

  logic accept;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Placement decision and next call state
  always_comb begin
    logic          push_en;
    logic [3:0]    push_bytes;
    logic [63:0]   push_val;
    logic [SW:0]   push_end;
    logic          arg_fp;
    logic [3:0]    int_max;

    abi_d  = abi_q;
    int_d  = int_q;
    fp_d   = fp_q;
    slot_d = slot_q;
    stk_d  = stk_q;
    pos_d  = pos_q;
    kind_d = cap_pkg::KIND_NONE;
    reg_d  = '0;
    off_d  = '0;
    data_d = '0;
    bw_d   = '0;
    clr_d  = 1'b0;
    drop_d = 1'b0;
    ic_d   = '0;
    fc_d   = '0;
    sb_d   = '0;
    ta_d   = '0;
    push_en    = 1'b0;
    push_bytes = cap_pkg::WideBytes;
    push_val   = in_value;
    arg_fp     = in_is_fp && (pos_q < cap_pkg::FpPosLimit);
    int_max    = (abi_q == cap_pkg::ABI_AAPCS) ? cap_pkg::AapcsIntRegs
                                               : cap_pkg::SysvIntRegs;

    unique case (in_func)
      cap_pkg::FUNC_BEGIN: begin
        abi_d  = cap_pkg::abi_e'(in_abi);
        int_d  = '0;
        fp_d   = '0;
        slot_d = '0;
        stk_d  = '0;
        pos_d  = '0;
        if (in_hsr && (in_saddr != 64'd0)) begin
          unique case (cap_pkg::abi_e'(in_abi))
            cap_pkg::ABI_SYSV: begin
              kind_d = cap_pkg::KIND_INT;
              data_d = in_saddr;
              int_d  = 4'd1;
            end
            cap_pkg::ABI_WIN: begin
              kind_d = cap_pkg::KIND_INT;
              data_d = in_saddr;
              clr_d  = 1'b1;
              slot_d = 3'd1;
            end
            cap_pkg::ABI_X86: begin
              // Stack is empty, the pointer always fits at offset zero
              kind_d = cap_pkg::KIND_STACK;
              data_d = {32'd0, in_saddr[31:0]};
              bw_d   = cap_pkg::NarrowBytes;
              stk_d  = SW'(cap_pkg::NarrowBytes);
            end
            cap_pkg::ABI_AAPCS: begin
              kind_d = cap_pkg::KIND_NONE;
            end
            default: kind_d = cap_pkg::KIND_NONE;
          endcase
        end
      end
      cap_pkg::FUNC_ARG: begin
        if (pos_q != cap_pkg::PosMax) pos_d = pos_q + 8'd1;
        unique case (abi_q)
          cap_pkg::ABI_WIN: begin
            if (slot_q < cap_pkg::WinSlots) begin
              kind_d = arg_fp ? cap_pkg::KIND_FP : cap_pkg::KIND_INT;
              reg_d  = slot_q;
              data_d = in_value;
              clr_d  = 1'b1;
              slot_d = slot_q + 3'd1;
              if (arg_fp) fp_d = fp_q + 4'd1;
            end else begin
              push_en = 1'b1;
            end
          end
          cap_pkg::ABI_X86: begin
            push_en    = 1'b1;
            push_bytes = arg_fp ? cap_pkg::WideBytes : cap_pkg::NarrowBytes;
          end
          default: begin
            if (arg_fp) begin
              if (fp_q < cap_pkg::FpRegs) begin
                kind_d = cap_pkg::KIND_FP;
                reg_d  = fp_q[2:0];
                data_d = in_value;
                fp_d   = fp_q + 4'd1;
              end else begin
                push_en = 1'b1;
              end
            end else if (int_q < int_max) begin
              kind_d = cap_pkg::KIND_INT;
              reg_d  = int_q[2:0];
              data_d = in_value;
              int_d  = int_q + 4'd1;
            end else begin
              push_en = 1'b1;
            end
          end
        endcase
      end
      cap_pkg::FUNC_END: begin
        kind_d = cap_pkg::KIND_REPORT;
        unique case (abi_q)
          cap_pkg::ABI_WIN: begin
            ic_d = {1'b0, slot_q};
            fc_d = fp_q;
          end
          cap_pkg::ABI_X86: begin
            ic_d = '0;
            fc_d = '0;
          end
          default: begin
            ic_d = int_q;
            fc_d = fp_q;
          end
        endcase
        sb_d = stk_q;
        ta_d = pos_q;
      end
      default: kind_d = cap_pkg::KIND_NONE;
    endcase

    // Stack push: drop when it would pass the limit
    push_end = {1'b0, stk_q} + (SW + 1)'(push_bytes);
    if (push_en) begin
      if (push_end > StackLimit) begin
        drop_d = 1'b1;
      end else begin
        kind_d = cap_pkg::KIND_STACK;
        off_d  = stk_q;
        data_d = (push_bytes == cap_pkg::NarrowBytes) ? {32'd0, push_val[31:0]}
                                                      : push_val;
        bw_d   = push_bytes;
        stk_d  = push_end[SW-1:0];
      end
    end
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abi_q       <= cap_pkg::ABI_SYSV;
      int_q       <= '0;
      fp_q        <= '0;
      slot_q      <= '0;
      stk_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        abi_q       <= abi_d;
        int_q       <= int_d;
        fp_q        <= fp_d;
        slot_q      <= slot_d;
        stk_q       <= stk_d;
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      reg_q  <= reg_d;
      off_q  <= off_d;
      data_q <= data_d;
      bw_q   <= bw_d;
      clr_q  <= clr_d;
      drop_q <= drop_d;
      ic_q   <= ic_d;
      fc_q   <= fc_d;
      sb_q   <= sb_d;
      ta_q   <= ta_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {(OutW - UsedW)'(0), ta_q, sb_q, fc_q, ic_q, drop_q, clr_q,
                          bw_q, data_q, off_q, reg_q};

endmodule

### tb/call_argument_placement_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_argument_placement_checker
// Watches both stream channels of the argument placement block, predicts the
// placement of every input transfer and compares each result transfer, field
// by field, with the oldest prediction. Hands the failure count and the number
// of outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module call_argument_placement_checker
  import cap_pkg::*;
#(
  parameter int unsigned StackBytes = 256,
  parameter int unsigned OffW       = $clog2(StackBytes + 1),
  parameter int unsigned OutDataW   = ((89 + 2 * OffW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [1:0]          s_tuser_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic [2:0]          m_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  output int                  errors_o,
  output int                  pending_o
);

  localparam int unsigned FieldW = 89 + 2 * OffW;

  // One placement result; kind comes from tuser, the rest maps onto tdata
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        arg_total;
    logic [OffW-1:0]   stack_bytes;
    logic [3:0]        fp_regs;
    logic [3:0]        int_count;
    logic              dropped;
    logic              clear;
    logic [3:0]        width;
    logic [63:0]       data;
    logic [OffW-1:0]   offset;
    logic [2:0]        reg_index;
  } placement_t;

  // Predicted call state
  abi_e            conv;
  logic [3:0]      ints_taken;
  logic [3:0]      fps_taken;
  logic [2:0]      slots_taken;
  logic [OffW-1:0] stack_taken;
  logic [7:0]      arg_pos;

  placement_t placements_due[$];
  int         mismatch_count;

  function automatic void clear_counters();
    conv        = ABI_SYSV;
    ints_taken  = '0;
    fps_taken   = '0;
    slots_taken = '0;
    stack_taken = '0;
    arg_pos     = '0;
  endfunction

  function automatic placement_t reg_write(kind_e k, logic [2:0] idx, logic [63:0] v,
                                           logic clr);
    placement_t r;
    r           = '0;
    r.kind      = k;
    r.reg_index = idx;
    r.data      = v;
    r.clear     = clr;
    return r;
  endfunction

  // Push onto the stack, or flag a drop when the push would pass the limit
  function automatic placement_t stack_push(logic [3:0] nbytes, logic [63:0] v);
    placement_t r;
    r = '0;
    if (int'(stack_taken) + int'(nbytes) > int'(StackBytes)) begin
      r.dropped = 1'b1;
    end else begin
      r.kind      = KIND_STACK;
      r.offset    = stack_taken;
      r.data      = (nbytes == NarrowBytes) ? {32'd0, v[31:0]} : v;
      r.width     = nbytes;
      stack_taken = stack_taken + OffW'(nbytes);
    end
    return r;
  endfunction

  function automatic placement_t predict_placement(func_e f, logic [InDataW-1:0] d);
    placement_t  r;
    abi_e        a;
    logic        want_ptr;
    logic [63:0] addr;
    logic [63:0] val;
    logic        fp_arg;
    logic [3:0]  int_limit;
    a        = abi_e'(d[1:0]);
    want_ptr = d[2];
    addr     = d[66:3];
    val      = d[131:68];
    // arguments from position eight on are placed as integers
    fp_arg   = d[67] && (arg_pos < FpPosLimit);
    r        = '0;
    case (f)
      FUNC_BEGIN: begin
        clear_counters();
        conv = a;
        if (want_ptr && addr != '0) begin
          case (a)
            ABI_SYSV: begin
              r          = reg_write(KIND_INT, 3'd0, addr, 1'b0);
              ints_taken = 4'd1;
            end
            ABI_WIN: begin
              r           = reg_write(KIND_INT, 3'd0, addr, 1'b1);
              slots_taken = 3'd1;
            end
            ABI_X86: r = stack_push(NarrowBytes, addr);
            default: ;
          endcase
        end
      end
      FUNC_ARG: begin
        case (conv)
          ABI_WIN: begin
            if (slots_taken < WinSlots) begin
              r = reg_write(fp_arg ? KIND_FP : KIND_INT, slots_taken, val, 1'b1);
              if (fp_arg) fps_taken = fps_taken + 4'd1;
              slots_taken = slots_taken + 3'd1;
            end else begin
              r = stack_push(WideBytes, val);
            end
          end
          ABI_X86: r = stack_push(fp_arg ? WideBytes : NarrowBytes, val);
          default: begin
            int_limit = (conv == ABI_AAPCS) ? AapcsIntRegs : SysvIntRegs;
            if (fp_arg) begin
              if (fps_taken < FpRegs) begin
                r         = reg_write(KIND_FP, fps_taken[2:0], val, 1'b0);
                fps_taken = fps_taken + 4'd1;
              end else begin
                r = stack_push(WideBytes, val);
              end
            end else if (ints_taken < int_limit) begin
              r          = reg_write(KIND_INT, ints_taken[2:0], val, 1'b0);
              ints_taken = ints_taken + 4'd1;
            end else begin
              r = stack_push(WideBytes, val);
            end
          end
        endcase
        if (arg_pos != PosMax) arg_pos = arg_pos + 8'd1;
      end
      FUNC_END: begin
        r.kind = KIND_REPORT;
        if (conv == ABI_WIN) begin
          r.int_count = {1'b0, slots_taken};
          r.fp_regs   = fps_taken;
        end else if (conv != ABI_X86) begin
          r.int_count = ints_taken;
          r.fp_regs   = fps_taken;
        end
        r.stack_bytes = stack_taken;
        r.arg_total   = arg_pos;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string describe(placement_t p);
    return $sformatf({"kind=%0d reg=%0d off=%0d data=%h bw=%0d clr=%0b drop=%0b ",
                      "ic=%0d fc=%0d sb=%0d ta=%0d"},
                     p.kind, p.reg_index, p.offset, p.data, p.width, p.clear,
                     p.dropped, p.int_count, p.fp_regs, p.stack_bytes, p.arg_total);
  endfunction

  function automatic void note_fault(string what, placement_t want, placement_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endfunction

  // Retire results against the oldest prediction, then predict new transfers
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    placement_t got;
    if (!rst_ni) begin
      clear_counters();
      placements_due.delete();
      mismatch_count = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = placement_t'({m_tuser_i, m_tdata_i[FieldW-1:0]});
        if (placements_due.size() == 0) begin
          note_fault("result transfer with no prediction waiting", '0, got);
        end else begin
          want = placements_due.pop_front();
          if (got !== want) note_fault("result transfer mismatch", want, got);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        placements_due.push_back(predict_placement(func_e'(s_tuser_i), s_tdata_i));
      end
      errors_o  <= mismatch_count;
      pending_o <= placements_due.size();
    end
  end

endmodule

### tb/call_argument_placement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_argument_placement_tb
// Drives begin, argument, end and no-op transfers into the argument placement
// block under all four calling conventions, with random stalls on both sides.
// The checker predicts and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module call_argument_placement_tb;
  import cap_pkg::*;

  localparam int unsigned StackBytes    = 256;
  localparam int unsigned OffW          = $clog2(StackBytes + 1);
  localparam int unsigned OutDataW      = ((89 + 2 * OffW + 7) / 8) * 8;
  localparam int unsigned ItemTarget    = 650;
  localparam int          WatchdogLimit = 2000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = FUNC_NOP;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [2:0]          m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  int mismatches;
  int pending;
  int idle_pct     = 20;
  int items_sent   = 0;
  int calls_sent   = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int drops_seen   = 0;
  int quiet_cycles = 0;

  call_argument_placement #(
    .STACK_BYTES(StackBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  call_argument_placement_checker #(
    .StackBytes(StackBytes)
  ) checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .s_tvalid_i(s_axis_tvalid),
    .s_tready_i(s_axis_tready),
    .m_tdata_i (m_axis_tdata),
    .m_tuser_i (m_axis_tuser),
    .m_tvalid_i(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .errors_o  (mismatches),
    .pending_o (pending)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Count transfers and end a run that has gone quiet
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (m_axis_tuser == KIND_REPORT) reports_seen <= reports_seen + 1;
        if (m_axis_tdata[OffW + 72]) drops_seen <= drops_seen + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one transfer, with a random gap in front, and hold until accepted
  task automatic send_item(func_e f, abi_e a, logic ptr, logic [63:0] addr, logic fp,
                           logic [63:0] val);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {4'd0, val, fp, addr, ptr, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (f == FUNC_BEGIN) calls_sent++;
  endtask

  task automatic send_arg();
    send_item(FUNC_ARG, abi_e'(2'($urandom)), 1'($urandom), pick_value(), 1'($urandom),
              pick_value());
  endtask

  // Drop the valid and hold until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One well-formed call with random content, sometimes left open or extended
  task automatic run_call(int unsigned nargs);
    logic [63:0] addr;
    addr = ($urandom_range(3) == 0) ? 64'd0 : pick_value();
    send_item(FUNC_BEGIN, abi_e'(2'($urandom)), 1'($urandom), addr, 1'($urandom),
              pick_value());
    repeat (nargs) send_arg();
    if ($urandom_range(9) != 0) begin
      send_item(FUNC_END, ABI_SYSV, 1'b0, pick_value(), 1'($urandom), pick_value());
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) send_arg();
        send_item(FUNC_END, ABI_SYSV, 1'b0, '0, 1'b0, '0);
      end
    end
  endtask

  initial begin
    bit long_done;
    long_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Arguments before any begin follow SysV with cleared counters
    send_item(FUNC_ARG, ABI_WIN, 1'b1, '1, 1'b0, '1);
    send_item(FUNC_ARG, ABI_X86, 1'b0, '0, 1'b1, '0);
    send_item(FUNC_NOP, ABI_AAPCS, 1'b1, '1, 1'b1, '1);
    send_item(FUNC_END, ABI_SYSV, 1'b0, '0, 1'b0, '0);
    // SysV with struct pointer of all ones
    send_item(FUNC_BEGIN, ABI_SYSV, 1'b1, '1, 1'b0, '0);
    send_item(FUNC_ARG, ABI_SYSV, 1'b0, '0, 1'b0, 64'h8000_0000_0000_0001);
    send_item(FUNC_ARG, ABI_SYSV, 1'b0, '0, 1'b1, 64'h7FF0_0000_0000_0000);
    // Windows: pointer takes slot zero, then the slots fill and spill
    send_item(FUNC_BEGIN, ABI_WIN, 1'b1, 64'h8000_0000_0000_0001, 1'b0, '0);
    send_item(FUNC_ARG, ABI_WIN, 1'b0, '0, 1'b1, 64'h3FF0_0000_0000_0000);
    send_item(FUNC_ARG, ABI_WIN, 1'b0, '0, 1'b0, 64'd42);
    send_item(FUNC_ARG, ABI_WIN, 1'b0, '0, 1'b1, '1);
    send_item(FUNC_ARG, ABI_WIN, 1'b0, '0, 1'b0, 64'hDEAD_BEEF_CAFE_F00D);
    send_item(FUNC_END, ABI_WIN, 1'b0, '0, 1'b0, '0);
    // x86-32: pointer and ints are 4-byte pushes, FP stays 8 bytes
    send_item(FUNC_BEGIN, ABI_X86, 1'b1, 64'hFFFF_FFFF_1234_5678, 1'b0, '0);
    send_item(FUNC_ARG, ABI_X86, 1'b0, '0, 1'b0, '1);
    send_item(FUNC_ARG, ABI_X86, 1'b0, '0, 1'b1, 64'hC000_0000_0000_0000);
    send_item(FUNC_END, ABI_X86, 1'b0, '0, 1'b0, '0);
    // AAPCS never inserts the pointer; zero pointer or no request inserts nothing
    send_item(FUNC_BEGIN, ABI_AAPCS, 1'b1, 64'h0000_0000_0000_1000, 1'b0, '0);
    send_item(FUNC_ARG, ABI_AAPCS, 1'b0, '0, 1'b0, 64'd7);
    send_item(FUNC_END, ABI_AAPCS, 1'b0, '0, 1'b0, '0);
    send_item(FUNC_BEGIN, ABI_SYSV, 1'b1, '0, 1'b0, '0);
    send_item(FUNC_BEGIN, ABI_WIN, 1'b0, '1, 1'b1, '1);
    send_item(FUNC_END, ABI_WIN, 1'b0, '0, 1'b0, '0);
    drain();

    // Random calls, short mostly, some long enough to spill and drop
    while (items_sent < ItemTarget) begin
      idle_pct <= (items_sent >= 300 && items_sent < 420) ? 0 : 20;
      if (!long_done && items_sent >= 200) begin
        // saturate the argument position, then let everything drain
        run_call(262);
        drain();
        long_done = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        send_item(func_e'(2'($urandom)), abi_e'(2'($urandom)), 1'($urandom), pick_value(),
                  1'($urandom), pick_value());
      end else if ($urandom_range(6) == 0) begin
        run_call($urandom_range(30, 70));
      end else begin
        run_call($urandom_range(0, 12));
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d transfers in %0d calls over all four conventions;",
             items_sent, calls_sent);
    $display("checked %0d results, %0d count reports and %0d dropped pushes.",
             results_seen, reports_seen, drops_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
